@@ design/pws_pkg.sv @@
// Shared types, register codes and constants for the world-to-screen projection block.
`timescale 1ns / 1ps

package pws_pkg;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_CAMERA_X    = 3'd0,
        REG_CAMERA_Y    = 3'd1,
        REG_CAMERA_Z    = 3'd2,
        REG_PITCH       = 3'd3,
        REG_YAW         = 3'd4,
        REG_ROLL        = 3'd5,
        REG_FOV         = 3'd6,
        REG_SCREEN_SIZE = 3'd7
    } cfg_idx_t;

    // Camera setup sequencer states.
    typedef enum logic [2:0] {
        SU_LOAD,
        SU_ROTATE,
        SU_MULT,
        SU_BASIS,
        SU_CHECK,
        SU_DIVIDE,
        SU_DONE
    } setup_state_t;

    // CORDIC start value: unit length with the gain folded in, Q28.
    localparam logic signed [31:0] Q28_GAIN = 32'sd163008219;

    // Width of the Q16 pixel scale factor.
    localparam int SCALE_W = 46;

    // Camera values derived from the configuration, held while points stream.
    typedef struct packed {
        logic                ready;
        logic                degen;
        logic [SCALE_W-1:0]  scale;
        logic [31:0]         fx;
        logic [31:0]         fy;
        logic [31:0]         fz;
        logic [31:0]         rx;
        logic [31:0]         ry;
        logic [31:0]         rz;
        logic [31:0]         ux;
        logic [31:0]         uy;
        logic [31:0]         uz;
    } camera_t;

    // Arctangent table of the CORDIC, in units of 2^18 per turn.
    function automatic logic [15:0] atan_val(input logic [4:0] idx);
        logic [15:0] v;
        case (idx)
            5'd0:    v = 16'd32768;
            5'd1:    v = 16'd19344;
            5'd2:    v = 16'd10221;
            5'd3:    v = 16'd5188;
            5'd4:    v = 16'd2604;
            5'd5:    v = 16'd1303;
            5'd6:    v = 16'd652;
            5'd7:    v = 16'd326;
            5'd8:    v = 16'd163;
            5'd9:    v = 16'd81;
            5'd10:   v = 16'd41;
            5'd11:   v = 16'd20;
            5'd12:   v = 16'd10;
            5'd13:   v = 16'd5;
            5'd14:   v = 16'd3;
            5'd15:   v = 16'd1;
            5'd16:   v = 16'd1;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

endpackage

@@ design/pws_setup.sv @@
// Camera setup sequencer: sine and cosine, basis vectors and pixel scale factor.
`timescale 1ns / 1ps

module pws_setup
    import pws_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        restart,
    input  logic [15:0] pitch_angle,
    input  logic [15:0] yaw_angle,
    input  logic [15:0] roll_angle,
    input  logic [14:0] fov_angle,
    input  logic [15:0] screen_width,
    output camera_t     cam
);

    localparam logic [4:0] ROT_LAST = 5'd16;
    localparam logic [3:0] MUL_LAST = 4'd13;
    localparam logic [5:0] DIV_LAST = 6'd62;

    setup_state_t state_reg, state_next;
    logic [1:0]   ang_sel_reg, ang_sel_next;
    logic [4:0]   iter_reg, iter_next;
    logic [3:0]   step_reg, step_next;
    logic [5:0]   cnt_reg, cnt_next;

    logic signed [31:0] x_reg, y_reg;
    logic signed [19:0] z_reg;
    logic               flip_reg;
    logic signed [31:0] sin_reg [4];
    logic signed [31:0] cos_reg [4];
    logic signed [31:0] prod_reg [14];
    logic [31:0]        fx_reg, fy_reg, fz_reg, rx_reg, ry_reg, rz_reg;
    logic [31:0]        ux_reg, uy_reg, uz_reg;
    logic               degen_reg;
    logic [62:0]        sh_reg;
    logic [30:0]        rem_reg;
    logic [30:0]        dvs_reg;
    logic [SCALE_W-1:0] quo_reg;

    logic [17:0]        ang18;
    logic signed [19:0] z_raw, z_load;
    logic               flip_load;
    logic signed [31:0] sh_x, sh_y, xn, yn;
    logic signed [19:0] zn, atan_z;
    logic signed [31:0] op_a, op_b;
    logic signed [63:0] prod, prod_sh;
    logic signed [46:0] sf_x10k, cf_ext;
    logic               degen_now;
    logic [30:0]        cf_pos;
    logic [46:0]        num;
    logic [31:0]        trial;
    logic               ge;

    // Angle selection and folding into the right half plane.
    always_comb begin
        case (ang_sel_reg)
            2'd0:    ang18 = {pitch_angle, 2'b00};
            2'd1:    ang18 = {yaw_angle, 2'b00};
            2'd2:    ang18 = {roll_angle, 2'b00};
            default: ang18 = {2'b00, fov_angle, 1'b0};
        endcase
        z_raw = $signed({{2{ang18[17]}}, ang18});
        z_load = z_raw;
        flip_load = 1'b0;
        if (z_raw > 20'sd65536) begin
            z_load = z_raw - 20'sd131072;
            flip_load = 1'b1;
        end else if (z_raw < -20'sd65536) begin
            z_load = z_raw + 20'sd131072;
            flip_load = 1'b1;
        end
    end

    // One CORDIC rotation step.
    always_comb begin
        sh_x = x_reg >>> iter_reg;
        sh_y = y_reg >>> iter_reg;
        atan_z = $signed({4'b0000, atan_val(iter_reg)});
        if (z_reg >= 20'sd0) begin
            xn = x_reg - sh_y;
            yn = y_reg + sh_x;
            zn = z_reg - atan_z;
        end else begin
            xn = x_reg + sh_y;
            yn = y_reg - sh_x;
            zn = z_reg + atan_z;
        end
    end

    // Operand selection for the shared Q28 multiplier.
    always_comb begin
        case (step_reg)
            4'd0:    begin op_a = cos_reg[0];  op_b = cos_reg[1]; end
            4'd1:    begin op_a = cos_reg[0];  op_b = sin_reg[1]; end
            4'd2:    begin op_a = sin_reg[0];  op_b = sin_reg[2]; end
            4'd3:    begin op_a = sin_reg[0];  op_b = cos_reg[2]; end
            4'd4:    begin op_a = prod_reg[2]; op_b = cos_reg[1]; end
            4'd5:    begin op_a = cos_reg[2];  op_b = sin_reg[1]; end
            4'd6:    begin op_a = prod_reg[2]; op_b = sin_reg[1]; end
            4'd7:    begin op_a = cos_reg[2];  op_b = cos_reg[1]; end
            4'd8:    begin op_a = sin_reg[2];  op_b = cos_reg[0]; end
            4'd9:    begin op_a = prod_reg[3]; op_b = cos_reg[1]; end
            4'd10:   begin op_a = sin_reg[2];  op_b = sin_reg[1]; end
            4'd11:   begin op_a = prod_reg[3]; op_b = sin_reg[1]; end
            4'd12:   begin op_a = sin_reg[2];  op_b = cos_reg[1]; end
            default: begin op_a = cos_reg[0];  op_b = cos_reg[2]; end
        endcase
        prod = op_a * op_b;
        prod_sh = prod >>> 28;
    end

    // Field of view test, numerator of the scale factor and the divider trial.
    always_comb begin
        sf_x10k = sin_reg[3] * 47'sd10000;
        cf_ext = $signed({{15{cos_reg[3][31]}}, cos_reg[3]});
        degen_now = (sin_reg[3] <= 32'sd0) || (sf_x10k < cf_ext);
        cf_pos = cos_reg[3][31] ? 31'd0 : cos_reg[3][30:0];
        num = 47'(screen_width) * 47'(cf_pos);
        trial = {rem_reg, sh_reg[62]};
        ge = trial >= {1'b0, dvs_reg};
    end

    // Next state and counters.
    always_comb begin
        state_next = state_reg;
        ang_sel_next = ang_sel_reg;
        iter_next = iter_reg;
        step_next = step_reg;
        cnt_next = cnt_reg;
        case (state_reg)
            SU_LOAD: begin
                iter_next = 5'd0;
                state_next = SU_ROTATE;
            end
            SU_ROTATE: begin
                if (iter_reg == ROT_LAST) begin
                    iter_next = 5'd0;
                    if (ang_sel_reg == 2'd3) begin
                        state_next = SU_MULT;
                        step_next = 4'd0;
                    end else begin
                        ang_sel_next = ang_sel_reg + 2'd1;
                        state_next = SU_LOAD;
                    end
                end else begin
                    iter_next = iter_reg + 5'd1;
                end
            end
            SU_MULT: begin
                if (step_reg == MUL_LAST) begin
                    state_next = SU_BASIS;
                end else begin
                    step_next = step_reg + 4'd1;
                end
            end
            SU_BASIS: state_next = SU_CHECK;
            SU_CHECK: begin
                cnt_next = 6'd0;
                state_next = degen_now ? SU_DONE : SU_DIVIDE;
            end
            SU_DIVIDE: begin
                if (cnt_reg == DIV_LAST) begin
                    state_next = SU_DONE;
                end else begin
                    cnt_next = cnt_reg + 6'd1;
                end
            end
            SU_DONE: state_next = SU_DONE;
            default: state_next = SU_LOAD;
        endcase
        if (restart) begin
            state_next = SU_LOAD;
            ang_sel_next = 2'd0;
        end
    end

    // Sequencer control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SU_LOAD;
            ang_sel_reg <= 2'd0;
            iter_reg <= 5'd0;
            step_reg <= 4'd0;
            cnt_reg <= 6'd0;
        end else begin
            state_reg <= state_next;
            ang_sel_reg <= ang_sel_next;
            iter_reg <= iter_next;
            step_reg <= step_next;
            cnt_reg <= cnt_next;
        end
    end

    // Datapath registers of the sequencer.
    always_ff @(posedge aclk) begin
        case (state_reg)
            SU_LOAD: begin
                x_reg <= Q28_GAIN;
                y_reg <= 32'sd0;
                z_reg <= z_load;
                flip_reg <= flip_load;
            end
            SU_ROTATE: begin
                x_reg <= xn;
                y_reg <= yn;
                z_reg <= zn;
                if (iter_reg == ROT_LAST) begin
                    sin_reg[ang_sel_reg] <= flip_reg ? -yn : yn;
                    cos_reg[ang_sel_reg] <= flip_reg ? -xn : xn;
                end
            end
            SU_MULT: prod_reg[step_reg] <= prod_sh[31:0];
            SU_BASIS: begin
                fx_reg <= prod_reg[0];
                fy_reg <= prod_reg[1];
                fz_reg <= sin_reg[0];
                rx_reg <= prod_reg[4] - prod_reg[5];
                ry_reg <= prod_reg[6] + prod_reg[7];
                rz_reg <= -prod_reg[8];
                ux_reg <= -prod_reg[9] - prod_reg[10];
                uy_reg <= prod_reg[12] - prod_reg[11];
                uz_reg <= prod_reg[13];
            end
            SU_CHECK: begin
                degen_reg <= degen_now;
                sh_reg <= {num, 16'd0};
                dvs_reg <= {sin_reg[3][29:0], 1'b0};
                rem_reg <= 31'd0;
                quo_reg <= '0;
            end
            SU_DIVIDE: begin
                rem_reg <= ge ? 31'(trial - {1'b0, dvs_reg}) : trial[30:0];
                quo_reg <= {quo_reg[SCALE_W-2:0], ge};
                sh_reg <= {sh_reg[61:0], 1'b0};
            end
            default: begin
            end
        endcase
    end

    // Values handed to the point pipeline.
    always_comb begin
        cam.ready = (state_reg == SU_DONE);
        cam.degen = degen_reg;
        cam.scale = quo_reg;
        cam.fx = fx_reg;
        cam.fy = fy_reg;
        cam.fz = fz_reg;
        cam.rx = rx_reg;
        cam.ry = ry_reg;
        cam.rz = rz_reg;
        cam.ux = ux_reg;
        cam.uy = uy_reg;
        cam.uz = uz_reg;
    end

endmodule

@@ design/perspective_world_to_screen_core.sv @@
// Top level: configuration registers and the point projection pipeline.
// Divider and multipliers are fully pipelined: s0, s1, s2, divider stages, m1, m2, output.
// Throughput is one point per cycle unless m_tready or the camera setup stalls the flow.
// Reset is synchronous active low and loads the register defaults (90 degree fov, 1920x1080).
// After reset and after every configuration write the camera setup runs (skipping the divide
// when the field of view is degenerate), and s_tready stays low during that pass.
`timescale 1ns / 1ps

module perspective_world_to_screen_core
    import pws_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [31:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // point_x [31:0], point_y [63:32], point_z [95:64]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // screen_x [31:0], screen_y [63:32]
    output logic        m_tuser    // visible
);

    localparam int DIV_STEPS = 54;

    // Configuration registers.
    logic [31:0] cam_x_reg, cam_y_reg, cam_z_reg;
    logic [15:0] pitch_reg, yaw_reg, roll_reg;
    logic [14:0] fov_reg;
    logic [31:0] screen_reg;
    camera_t     cam;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cam_x_reg <= 32'd0;
            cam_y_reg <= 32'd0;
            cam_z_reg <= 32'd0;
            pitch_reg <= 16'd0;
            yaw_reg <= 16'd0;
            roll_reg <= 16'd0;
            fov_reg <= 15'd16384;
            screen_reg <= 32'd125830200;
        end else if (cfg_we) begin
            case (cfg_idx_t'(cfg_addr))
                REG_CAMERA_X:    cam_x_reg <= cfg_wdata;
                REG_CAMERA_Y:    cam_y_reg <= cfg_wdata;
                REG_CAMERA_Z:    cam_z_reg <= cfg_wdata;
                REG_PITCH:       pitch_reg <= cfg_wdata[15:0];
                REG_YAW:         yaw_reg <= cfg_wdata[15:0];
                REG_ROLL:        roll_reg <= cfg_wdata[15:0];
                REG_FOV:         fov_reg <= cfg_wdata[14:0];
                REG_SCREEN_SIZE: screen_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Camera setup sequencer.
    pws_setup u_setup (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .restart      (cfg_we),
        .pitch_angle  (pitch_reg),
        .yaw_angle    (yaw_reg),
        .roll_angle   (roll_reg),
        .fov_angle    (fov_reg),
        .screen_width (screen_reg[31:16]),
        .cam          (cam)
    );

    // Pipeline registers.
    logic               s0_valid_reg, s1_valid_reg, s2_valid_reg, m1_valid_reg, m2_valid_reg;
    logic               m_valid_reg;
    logic signed [32:0] s0_d_reg [3];
    logic signed [64:0] s1_p_reg [9];
    logic signed [66:0] s2_depth_reg, s2_side_reg, s2_vert_reg;

    logic [DIV_STEPS:0] dv_valid_reg;
    logic [DIV_STEPS:0] dv_en;
    logic [66:0]        rem_s_reg [DIV_STEPS+1];
    logic [66:0]        rem_v_reg [DIV_STEPS+1];
    logic [53:0]        nb_s_reg [DIV_STEPS+1];
    logic [53:0]        nb_v_reg [DIV_STEPS+1];
    logic [53:0]        q_s_reg [DIV_STEPS+1];
    logic [53:0]        q_v_reg [DIV_STEPS+1];
    logic [66:0]        den_reg [DIV_STEPS+1];
    logic [DIV_STEPS:0] inv_reg, sgn_s_reg, sgn_v_reg;

    logic [66:0]        rem_s_step [DIV_STEPS];
    logic [66:0]        rem_v_step [DIV_STEPS];
    logic [53:0]        q_s_step [DIV_STEPS];
    logic [53:0]        q_v_step [DIV_STEPS];

    logic [49:0]        pp_s_reg [4];
    logic [49:0]        pp_v_reg [4];
    logic               m1_inv_reg, m1_sgn_s_reg, m1_sgn_v_reg;
    logic [99:0]        sum_s_reg, sum_v_reg;
    logic               m2_inv_reg, m2_sgn_s_reg, m2_sgn_v_reg;
    logic [63:0]        m_tdata_reg;
    logic               m_tuser_reg;

    logic en_out, en_m2, en_m1, en_s2, en_s1, en_s0;
    logic [66:0] mag_s, mag_v;
    logic        inv_now;

    // Stall chain: a stage moves when it is empty or its successor moves.
    assign en_out = !m_valid_reg || m_tready;
    assign en_m2 = !m2_valid_reg || en_out;
    assign en_m1 = !m1_valid_reg || en_m2;
    assign dv_en[DIV_STEPS] = !dv_valid_reg[DIV_STEPS] || en_m1;
    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_en
        assign dv_en[g] = !dv_valid_reg[g] || dv_en[g+1];
    end
    assign en_s2 = !s2_valid_reg || dv_en[0];
    assign en_s1 = !s1_valid_reg || en_s2;
    assign en_s0 = !s0_valid_reg || en_s1;
    assign s_tready = en_s0 && cam.ready;

    // Valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            dv_valid_reg <= '0;
            m1_valid_reg <= 1'b0;
            m2_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (en_s0) s0_valid_reg <= s_tvalid && cam.ready;
            if (en_s1) s1_valid_reg <= s0_valid_reg;
            if (en_s2) s2_valid_reg <= s1_valid_reg;
            if (dv_en[0]) dv_valid_reg[0] <= s2_valid_reg;
            for (int k = 0; k < DIV_STEPS; k++) begin
                if (dv_en[k+1]) dv_valid_reg[k+1] <= dv_valid_reg[k];
            end
            if (en_m1) m1_valid_reg <= dv_valid_reg[DIV_STEPS];
            if (en_m2) m2_valid_reg <= m1_valid_reg;
            if (en_out) m_valid_reg <= m2_valid_reg;
        end
    end

    // Offsets from the camera, basis products and dot products.
    always_ff @(posedge aclk) begin
        if (en_s0) begin
            s0_d_reg[0] <= $signed({s_tdata[31], s_tdata[31:0]})
                         - $signed({cam_x_reg[31], cam_x_reg});
            s0_d_reg[1] <= $signed({s_tdata[63], s_tdata[63:32]})
                         - $signed({cam_y_reg[31], cam_y_reg});
            s0_d_reg[2] <= $signed({s_tdata[95], s_tdata[95:64]})
                         - $signed({cam_z_reg[31], cam_z_reg});
        end
        if (en_s1) begin
            s1_p_reg[0] <= s0_d_reg[0] * $signed(cam.fx);
            s1_p_reg[1] <= s0_d_reg[1] * $signed(cam.fy);
            s1_p_reg[2] <= s0_d_reg[2] * $signed(cam.fz);
            s1_p_reg[3] <= s0_d_reg[0] * $signed(cam.rx);
            s1_p_reg[4] <= s0_d_reg[1] * $signed(cam.ry);
            s1_p_reg[5] <= s0_d_reg[2] * $signed(cam.rz);
            s1_p_reg[6] <= s0_d_reg[0] * $signed(cam.ux);
            s1_p_reg[7] <= s0_d_reg[1] * $signed(cam.uy);
            s1_p_reg[8] <= s0_d_reg[2] * $signed(cam.uz);
        end
        if (en_s2) begin
            s2_depth_reg <= $signed({{2{s1_p_reg[0][64]}}, s1_p_reg[0]})
                          + $signed({{2{s1_p_reg[1][64]}}, s1_p_reg[1]})
                          + $signed({{2{s1_p_reg[2][64]}}, s1_p_reg[2]});
            s2_side_reg <= $signed({{2{s1_p_reg[3][64]}}, s1_p_reg[3]})
                         + $signed({{2{s1_p_reg[4][64]}}, s1_p_reg[4]})
                         + $signed({{2{s1_p_reg[5][64]}}, s1_p_reg[5]});
            s2_vert_reg <= $signed({{2{s1_p_reg[6][64]}}, s1_p_reg[6]})
                         + $signed({{2{s1_p_reg[7][64]}}, s1_p_reg[7]})
                         + $signed({{2{s1_p_reg[8][64]}}, s1_p_reg[8]});
        end
    end

    // Magnitudes and visibility ahead of the divider.
    always_comb begin
        mag_s = s2_side_reg[66] ? 67'(-s2_side_reg) : s2_side_reg;
        mag_v = s2_vert_reg[66] ? 67'(-s2_vert_reg) : s2_vert_reg;
        inv_now = (s2_depth_reg < 67'sd68719476736) || cam.degen;
    end

    // One restoring quotient bit per divider stage, for both ratios.
    always_comb begin
        logic [67:0] tr_s, tr_v;
        logic        ge_s, ge_v;
        for (int k = 0; k < DIV_STEPS; k++) begin
            tr_s = {rem_s_reg[k], nb_s_reg[k][53]};
            tr_v = {rem_v_reg[k], nb_v_reg[k][53]};
            ge_s = tr_s >= {1'b0, den_reg[k]};
            ge_v = tr_v >= {1'b0, den_reg[k]};
            rem_s_step[k] = ge_s ? 67'(tr_s - {1'b0, den_reg[k]}) : tr_s[66:0];
            rem_v_step[k] = ge_v ? 67'(tr_v - {1'b0, den_reg[k]}) : tr_v[66:0];
            q_s_step[k] = {q_s_reg[k][52:0], ge_s};
            q_v_step[k] = {q_v_reg[k][52:0], ge_v};
        end
    end

    // Divider stage registers.
    always_ff @(posedge aclk) begin
        if (dv_en[0]) begin
            rem_s_reg[0] <= {30'd0, mag_s[66:30]};
            rem_v_reg[0] <= {30'd0, mag_v[66:30]};
            nb_s_reg[0] <= {mag_s[29:0], 24'd0};
            nb_v_reg[0] <= {mag_v[29:0], 24'd0};
            q_s_reg[0] <= '0;
            q_v_reg[0] <= '0;
            den_reg[0] <= s2_depth_reg;
            inv_reg[0] <= inv_now;
            sgn_s_reg[0] <= s2_side_reg[66];
            sgn_v_reg[0] <= s2_vert_reg[66];
        end
        for (int k = 0; k < DIV_STEPS; k++) begin
            if (dv_en[k+1]) begin
                rem_s_reg[k+1] <= rem_s_step[k];
                rem_v_reg[k+1] <= rem_v_step[k];
                nb_s_reg[k+1] <= {nb_s_reg[k][52:0], 1'b0};
                nb_v_reg[k+1] <= {nb_v_reg[k][52:0], 1'b0};
                q_s_reg[k+1] <= q_s_step[k];
                q_v_reg[k+1] <= q_v_step[k];
                den_reg[k+1] <= den_reg[k];
                inv_reg[k+1] <= inv_reg[k];
                sgn_s_reg[k+1] <= sgn_s_reg[k];
                sgn_v_reg[k+1] <= sgn_v_reg[k];
            end
        end
    end

    // Ratio times scale: saturate at 2^23 pixels (2^31 in Q8), sign, center and clamp.
    function automatic logic [31:0] place(input logic [99:0] p, input logic neg,
                                          input logic [15:0] base);
        logic [67:0]        tsh;
        logic [31:0]        t;
        logic signed [33:0] off, sum;
        logic [31:0]        res;
        tsh = p[99:32];
        t = (tsh > 68'h8000_0000) ? 32'h8000_0000 : tsh[31:0];
        off = neg ? -$signed({2'b00, t}) : $signed({2'b00, t});
        sum = $signed({11'd0, base, 7'd0}) + off;
        if (sum > 34'sd2147483647) begin
            res = 32'h7FFF_FFFF;
        end else if (sum < -34'sd2147483648) begin
            res = 32'h8000_0000;
        end else begin
            res = sum[31:0];
        end
        return res;
    endfunction

    // Partial products, their sum, and the output register.
    always_ff @(posedge aclk) begin
        if (en_m1) begin
            pp_s_reg[0] <= 50'(q_s_reg[DIV_STEPS][53:27]) * 50'(cam.scale[45:23]);
            pp_s_reg[1] <= 50'(q_s_reg[DIV_STEPS][53:27]) * 50'(cam.scale[22:0]);
            pp_s_reg[2] <= 50'(q_s_reg[DIV_STEPS][26:0]) * 50'(cam.scale[45:23]);
            pp_s_reg[3] <= 50'(q_s_reg[DIV_STEPS][26:0]) * 50'(cam.scale[22:0]);
            pp_v_reg[0] <= 50'(q_v_reg[DIV_STEPS][53:27]) * 50'(cam.scale[45:23]);
            pp_v_reg[1] <= 50'(q_v_reg[DIV_STEPS][53:27]) * 50'(cam.scale[22:0]);
            pp_v_reg[2] <= 50'(q_v_reg[DIV_STEPS][26:0]) * 50'(cam.scale[45:23]);
            pp_v_reg[3] <= 50'(q_v_reg[DIV_STEPS][26:0]) * 50'(cam.scale[22:0]);
            m1_inv_reg <= inv_reg[DIV_STEPS];
            m1_sgn_s_reg <= sgn_s_reg[DIV_STEPS];
            m1_sgn_v_reg <= sgn_v_reg[DIV_STEPS];
        end
        if (en_m2) begin
            sum_s_reg <= (100'(pp_s_reg[0]) << 50) + (100'(pp_s_reg[1]) << 27)
                       + (100'(pp_s_reg[2]) << 23) + 100'(pp_s_reg[3]);
            sum_v_reg <= (100'(pp_v_reg[0]) << 50) + (100'(pp_v_reg[1]) << 27)
                       + (100'(pp_v_reg[2]) << 23) + 100'(pp_v_reg[3]);
            m2_inv_reg <= m1_inv_reg;
            m2_sgn_s_reg <= m1_sgn_s_reg;
            m2_sgn_v_reg <= m1_sgn_v_reg;
        end
        if (en_out) begin
            if (m2_inv_reg) begin
                m_tdata_reg <= 64'd0;
                m_tuser_reg <= 1'b0;
            end else begin
                m_tdata_reg <= {place(sum_v_reg, !m2_sgn_v_reg, screen_reg[15:0]),
                                place(sum_s_reg, m2_sgn_s_reg, screen_reg[31:16])};
                m_tuser_reg <= 1'b1;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata = m_tdata_reg;
    assign m_tuser = m_tuser_reg;

endmodule
